[rtl/assert_macros.svh]
// Assertion helpers; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLY(label, cond, expr)
`define ASSERT_NEXT(label, cond, expr)
`endif
`endif

[rtl/bss_pkg.sv]
package bss_pkg;

    localparam int DATA_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int LIMIT_W  = 16;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_HAY    = 2'd2,
        OP_END    = 2'd3
    } t_op;

    // Per-cycle commands broadcast to every cell of the row
    typedef struct packed {
        logic shift_win;
        logic clr_win;
        logic shift_ndl;
        logic clr_ndl;
    } t_cell_ctl;

endpackage

[rtl/bss_cell.sv]
module bss_cell import bss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_win,
    input  logic [DATA_W-1:0] i_ndl,
    input  logic              i_act,
    output logic [DATA_W-1:0] o_win,
    output logic [DATA_W-1:0] o_ndl,
    output logic              o_act,
    output logic              o_hit
);

    logic [DATA_W-1:0] r_win;
    logic [DATA_W-1:0] r_ndl;
    logic              r_act;
    logic              r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_act <= 1'b0;
        end else begin
            if (i_ctl.clr_win) begin
                r_win <= '0;
            end else if (i_ctl.shift_win) begin
                r_win <= i_win;
            end
            if (i_ctl.clr_ndl) begin
                r_act <= 1'b0;
            end else if (i_ctl.shift_ndl) begin
                r_act <= i_act;
            end
        end
    end

    // Latch needle byte; hit if cell inactive or left byte equals needle byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_ndl) begin
            r_ndl <= i_ndl;
        end
        if (i_ctl.shift_win) begin
            r_hit <= !r_act || (i_win == r_ndl);
        end
    end

    assign o_win = r_win;
    assign o_ndl = r_ndl;
    assign o_act = r_act;
    assign o_hit = r_hit;

endmodule

[rtl/bounded_substring_search_core.sv]
// channel | signals                               | direction
// --------+---------------------------------------+----------
// in      | i_in_valid/o_in_ready, operation,byte | to core
// out     | o_out_valid/i_out_ready, found,offset | from core
// cfg     | i_cfg_we, i_cfg_data (search limit)   | to core
// One item per cycle while not stalled: each byte shifts into a row of
// NEEDLE_MAX cells that compare it with the needle; the registered hit
// bits are ANDed in the back stage, which registers each end result.
// Synchronous active-low reset clears window, needle length, counters.
// Input stalls only while an end item waits for a full, untaken output.
`include "assert_macros.svh"

module bounded_substring_search_core import bss_pkg::*; #(
    parameter int NEEDLE_MAX    = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LIMIT_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_operation,
    input  logic [DATA_W-1:0]   i_data_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_found,
    output logic [OFFSET_W-1:0] o_match_offset,
    output logic                o_needle_truncated
);

    localparam int LW = $clog2(NEEDLE_MAX + 1);
    localparam int PW = POSITION_BITS + 1;
    localparam int CW = ((PW > LIMIT_W) ? PW : LIMIT_W) + 1;

    logic [LIMIT_W-1:0] r_limit;
    logic [LW-1:0]      r_len;
    logic               r_ovf;
    logic               r_ended;
    logic [PW-1:0]      r_pos;

    logic               r_s2_valid;
    t_op                r_s2_op;
    logic               r_s2_cand;
    logic [OFFSET_W-1:0] r_s2_off;
    logic               r_s2_empty;
    logic               r_s2_ovf;

    logic               r_match_seen;
    logic [OFFSET_W-1:0] r_match_off;

    logic               r_out_valid;
    logic               r_out_found;
    logic [OFFSET_W-1:0] r_out_offset;
    logic               r_out_trunc;

    t_cell_ctl          w_ctl;
    t_op                w_op;
    logic               w_accept;
    logic               w_stall;
    logic               w_hay_take;
    logic               w_ndl_take;
    logic [CW-1:0]      w_pos1;
    logic               w_cand;
    logic [CW-1:0]      w_off;
    logic               w_all_hit;

    logic [DATA_W-1:0]  w_win [NEEDLE_MAX+1];
    logic [DATA_W-1:0]  w_ndl [NEEDLE_MAX+1];
    logic [NEEDLE_MAX:0] w_act;
    logic [NEEDLE_MAX-1:0] w_hit;

    assign w_op     = t_op'(i_operation);
    assign w_stall  = r_s2_valid && (r_s2_op == OP_END) && r_out_valid && !i_out_ready;
    assign o_in_ready = !w_stall;
    assign w_accept = i_in_valid && !w_stall;

    assign w_hay_take = w_accept && (w_op == OP_HAY) && !r_ended && (i_data_byte != '0);
    assign w_ndl_take = w_accept && (w_op == OP_APPEND) && (i_data_byte != '0)
                        && (r_len < LW'(NEEDLE_MAX));

    always_comb begin
        w_ctl.shift_win = w_hay_take;
        w_ctl.clr_win   = w_accept && (w_op != OP_HAY);
        w_ctl.shift_ndl = w_ndl_take;
        w_ctl.clr_ndl   = w_accept && (w_op == OP_CLEAR);
    end

    // Match window ends at this byte: start = pos + 1 - len
    assign w_pos1 = CW'(r_pos) + CW'(1);
    assign w_cand = (r_len != '0) && !r_pos[POSITION_BITS]
                    && (w_pos1 >= CW'(r_len)) && (w_pos1 <= CW'(r_limit));
    assign w_off  = w_pos1 - CW'(r_len);

    // Row of cells: window and needle shift rightward, newest at cell 0
    assign w_win[0] = i_data_byte;
    assign w_ndl[0] = i_data_byte;
    assign w_act[0] = 1'b1;

    for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
        bss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_win   (w_win[k]),
            .i_ndl   (w_ndl[k]),
            .i_act   (w_act[k]),
            .o_win   (w_win[k+1]),
            .o_ndl   (w_ndl[k+1]),
            .o_act   (w_act[k+1]),
            .o_hit   (w_hit[k])
        );
    end

    assign w_all_hit = &w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= '0;
            r_len        <= '0;
            r_ovf        <= 1'b0;
            r_ended      <= 1'b0;
            r_pos        <= '0;
            r_s2_valid   <= 1'b0;
            r_match_seen <= 1'b0;
            r_match_off  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end

            // Front: needle and window state, advanced at acceptance
            if (w_accept) begin
                unique case (w_op)
                    OP_CLEAR: begin
                        r_len   <= '0;
                        r_ovf   <= 1'b0;
                        r_ended <= 1'b0;
                        r_pos   <= '0;
                    end
                    OP_APPEND: begin
                        if (w_ndl_take) begin
                            r_len <= r_len + LW'(1);
                        end else if (i_data_byte != '0) begin
                            r_ovf <= 1'b1;
                        end
                        r_ended <= 1'b0;
                        r_pos   <= '0;
                    end
                    OP_HAY: begin
                        if (!r_ended && (i_data_byte == '0)) begin
                            r_ended <= 1'b1;
                        end
                        if (w_hay_take && !r_pos[POSITION_BITS]) begin
                            r_pos <= r_pos + PW'(1);
                        end
                    end
                    OP_END: begin
                        r_ended <= 1'b0;
                        r_pos   <= '0;
                    end
                    default: ;
                endcase
            end

            if (!w_stall) begin
                r_s2_valid <= w_accept;
            end

            // Back: resolve the match and emit the result
            if (r_s2_valid && !w_stall) begin
                unique case (r_s2_op)
                    OP_HAY: begin
                        if (r_s2_cand && w_all_hit && !r_match_seen) begin
                            r_match_seen <= 1'b1;
                            r_match_off  <= r_s2_off;
                        end
                    end
                    OP_CLEAR, OP_APPEND, OP_END: begin
                        r_match_seen <= 1'b0;
                        r_match_off  <= '0;
                    end
                    default: ;
                endcase
            end

            if (r_s2_valid && !w_stall && (r_s2_op == OP_END)) begin
                r_out_valid  <= 1'b1;
                r_out_found  <= r_s2_empty || r_match_seen;
                r_out_offset <= (r_match_seen && !r_s2_empty) ? r_match_off : '0;
                r_out_trunc  <= r_s2_ovf;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload for the back stage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s2_op    <= w_op;
            r_s2_cand  <= w_cand && w_hay_take;
            r_s2_off   <= w_off[OFFSET_W-1:0];
            r_s2_empty <= (r_len == '0);
            r_s2_ovf   <= r_ovf;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_found            = r_out_found;
    assign o_match_offset     = r_out_offset;
    assign o_needle_truncated = r_out_trunc;

    `ASSERT_ALWAYS(a_len_bound, r_len <= LW'(NEEDLE_MAX))
    `ASSERT_ALWAYS(a_act_len, $countones(w_act[NEEDLE_MAX:1]) == int'(r_len))
    `ASSERT_IMPLY(a_miss_zero, r_out_valid && !r_out_found, r_out_offset == '0)
    `ASSERT_NEXT(a_clear_len, w_accept && (w_op == OP_CLEAR), (r_len == '0) && !r_ovf)

endmodule
